[rtl/core/pgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise gravity step package
// Shared widths, register codes, reset values, side-band types and the
// saturating helpers used across the gravity step pipeline.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int WORD_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic [WORD_W-1:0] GRAVITY_RESET   = 32'd65536;
    localparam logic [WORD_W-1:0] TIME_STEP_RESET = 32'd655;
    localparam logic [WORD_W-1:0] MIN_DIST_RESET  = 32'd65536;

    typedef enum logic [1:0] {
        CFG_GRAVITY   = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_MIN_DIST  = 2'd2
    } t_cfg_idx;

    // Everything an item carries alongside the arithmetic lanes.
    typedef struct packed {
        logic signed [WORD_W-1:0] sx;
        logic signed [WORD_W-1:0] sy;
        logic signed [WORD_W-1:0] vx;
        logic signed [WORD_W-1:0] vy;
        logic        [WORD_W-1:0] mass;
        logic        [WORD_W-1:0] mx;
        logic        [WORD_W-1:0] my;
        logic                     neg_x;
        logic                     neg_y;
        logic                     sat;
        logic                     skip;
    } t_side;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_x;
        logic signed [WORD_W-1:0] new_y;
        logic signed [WORD_W-1:0] new_vx;
        logic signed [WORD_W-1:0] new_vy;
        logic                     skipped;
        logic                     saturated;
    } t_result;

    // Saturate a 50-bit signed sum to 32 bits.
    function automatic logic signed [WORD_W-1:0] clamp50(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_0000_7FFF_FFFF;
        lo = -50'sh0_0000_8000_0000;
        if (v > hi) begin
            clamp50 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            clamp50 = 32'sh8000_0000;
        end else begin
            clamp50 = v[WORD_W-1:0];
        end
    endfunction

    function automatic logic ovf50(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_0000_7FFF_FFFF;
        lo = -50'sh0_0000_8000_0000;
        ovf50 = (v > hi) || (v < lo);
    endfunction

endpackage

[rtl/core/pgs_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One digit-pair of the classic bitwise root per stage, 32 stages, with the
// item side-band travelling next to the partial root.
// ----------------------------------------------------------------------------
module pgs_sqrt
    import pgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_radicand,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic [63:0] r_s   [SQRT_STEPS];
    logic [63:0] r_res [SQRT_STEPS];
    t_side       r_side[SQRT_STEPS];
    logic        r_v   [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] s_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic [63:0] n_s;
        logic [63:0] n_res;
        logic        v_in;
        t_side       side_in;

        if (k == 0) begin : g_first
            assign s_in    = i_radicand;
            assign res_in  = 64'd0;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign s_in    = r_s[k-1];
            assign res_in  = r_res[k-1];
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (s_in >= trial) begin
                n_s   = s_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_s   = s_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]    <= n_s;
                r_res[k]  <= n_res;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][31:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

[rtl/core/pgs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider, three lanes
// Acceleration lane: G*m*2^16 / d^2 with overflow detection. Direction lanes:
// |dx|*2^16 / d and |dy|*2^16 / d. One quotient bit per lane per stage.
// ----------------------------------------------------------------------------
module pgs_div
    import pgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_gm,
    input  logic [63:0] i_d2,
    input  logic [31:0] i_d,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_acc,
    output logic        o_acc_sat,
    output logic [16:0] o_ux,
    output logic [16:0] o_uy,
    output t_side       o_side
);

    logic [63:0] r_ra  [DIV_STEPS];
    logic [31:0] r_qa  [DIV_STEPS];
    logic [31:0] r_rx  [DIV_STEPS];
    logic [31:0] r_qx  [DIV_STEPS];
    logic [31:0] r_ry  [DIV_STEPS];
    logic [31:0] r_qy  [DIV_STEPS];
    logic [63:0] r_d2  [DIV_STEPS];
    logic [31:0] r_d   [DIV_STEPS];
    logic        r_ovf [DIV_STEPS];
    t_side       r_side[DIV_STEPS];
    logic        r_v   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] ra_in;
        logic [31:0] qa_in;
        logic [31:0] rx_in;
        logic [31:0] qx_in;
        logic [31:0] ry_in;
        logic [31:0] qy_in;
        logic [63:0] d2_in;
        logic [31:0] d_in;
        logic        ovf_in;
        logic        v_in;
        t_side       side_in;
        logic [64:0] ta;
        logic [32:0] tx;
        logic [32:0] ty;
        logic        ga;
        logic        gx;
        logic        gy;
        logic [63:0] n_ra;
        logic [31:0] n_rx;
        logic [31:0] n_ry;

        if (k == 0) begin : g_first
            // The upper numerator bits start as the remainder; the low 32 bits
            // are shifted in one per stage from the quotient register.
            assign ra_in   = {16'd0, i_gm[63:16]};
            assign qa_in   = {i_gm[15:0], 16'd0};
            assign rx_in   = {16'd0, i_side.mx[31:16]};
            assign qx_in   = {i_side.mx[15:0], 16'd0};
            assign ry_in   = {16'd0, i_side.my[31:16]};
            assign qy_in   = {i_side.my[15:0], 16'd0};
            assign d2_in   = i_d2;
            assign d_in    = i_d;
            assign ovf_in  = ({16'd0, i_gm[63:16]} >= i_d2);
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign ra_in   = r_ra[k-1];
            assign qa_in   = r_qa[k-1];
            assign rx_in   = r_rx[k-1];
            assign qx_in   = r_qx[k-1];
            assign ry_in   = r_ry[k-1];
            assign qy_in   = r_qy[k-1];
            assign d2_in   = r_d2[k-1];
            assign d_in    = r_d[k-1];
            assign ovf_in  = r_ovf[k-1];
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            ta   = {ra_in, qa_in[31]};
            tx   = {rx_in, qx_in[31]};
            ty   = {ry_in, qy_in[31]};
            ga   = (ta >= {1'b0, d2_in});
            gx   = (tx >= {1'b0, d_in});
            gy   = (ty >= {1'b0, d_in});
            n_ra = ga ? 64'(ta - {1'b0, d2_in}) : ta[63:0];
            n_rx = gx ? 32'(tx - {1'b0, d_in}) : tx[31:0];
            n_ry = gy ? 32'(ty - {1'b0, d_in}) : ty[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ra[k]   <= n_ra;
                r_qa[k]   <= {qa_in[30:0], ga};
                r_rx[k]   <= n_rx;
                r_qx[k]   <= {qx_in[30:0], gx};
                r_ry[k]   <= n_ry;
                r_qy[k]   <= {qy_in[30:0], gy};
                r_d2[k]   <= d2_in;
                r_d[k]    <= d_in;
                r_ovf[k]  <= ovf_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid   = r_v[DIV_STEPS-1];
    assign o_acc_sat = r_ovf[DIV_STEPS-1];
    assign o_acc     = r_ovf[DIV_STEPS-1] ? 32'hFFFF_FFFF : r_qa[DIV_STEPS-1];
    assign o_ux      = r_qx[DIV_STEPS-1][16:0];
    assign o_uy      = r_qy[DIV_STEPS-1][16:0];
    assign o_side    = r_side[DIV_STEPS-1];

endmodule

[rtl/core/pairwise_gravity_euler_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise gravity semi-implicit Euler step, 2-D, signed Q16.16
// Updates one body's velocity and position under the pull of one partner.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the skid slot is empty and
// returns one result per request, in order. Most of the pipeline depth lies
// in the two bit-per-stage units: a 32-stage square root for the separation
// and a 32-stage divider that forms the acceleration and the unit direction
// together. The difference, the squares, the sum of squares, the skip
// decision, the multiplies and the saturating adds take eight more register
// stages, and the output register takes one.
// The whole pipeline advances as one while the output skid slot is empty, so
// a result that waits at the output does not hold back the next request; the
// input side stops only when both the output register and the skid slot are
// full. Configuration writes are always taken and should only be issued while
// no request is in flight.
// ----------------------------------------------------------------------------
module pairwise_gravity_euler_step_top
    import pgs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [WORD_W-1:0]  i_cfg_data,
    // Request channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_self_x,
    input  logic signed [31:0] i_self_y,
    input  logic signed [31:0] i_self_vx,
    input  logic signed [31:0] i_self_vy,
    input  logic signed [31:0] i_partner_x,
    input  logic signed [31:0] i_partner_y,
    input  logic [31:0]        i_partner_mass,
    // Result channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_vx,
    output logic signed [31:0] o_new_vy,
    output logic               o_skipped,
    output logic               o_saturated
);

    // Configuration registers.
    logic [WORD_W-1:0] r_gravity;
    logic [WORD_W-1:0] r_time_step;
    logic [WORD_W-1:0] r_min_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GRAVITY_RESET;
            r_time_step <= TIME_STEP_RESET;
            r_min_dist  <= MIN_DIST_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRAVITY:   r_gravity   <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Pipeline enable: everything moves while the skid slot is free.
    logic r_s_valid;
    logic en;
    assign en      = !r_s_valid;
    assign o_ready = en;

    // ------------------------------------------------------------------
    // Stage A: difference vector, clamped to 32 bits, split into sign and
    // magnitude.
    // ------------------------------------------------------------------
    logic signed [32:0] dfx;
    logic signed [32:0] dfy;
    logic signed [31:0] cdx;
    logic signed [31:0] cdy;
    logic               ovx;
    logic               ovy;
    t_side              n_a_side;
    t_side              r_a_side;
    logic               r_a_v;

    always_comb begin
        dfx = 33'(i_partner_x) - 33'(i_self_x);
        dfy = 33'(i_partner_y) - 33'(i_self_y);
        ovx = dfx[32] != dfx[31];
        ovy = dfy[32] != dfy[31];
        cdx = ovx ? (dfx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dfx[31:0];
        cdy = ovy ? (dfy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dfy[31:0];
        n_a_side.sx    = i_self_x;
        n_a_side.sy    = i_self_y;
        n_a_side.vx    = i_self_vx;
        n_a_side.vy    = i_self_vy;
        n_a_side.mass  = i_partner_mass;
        n_a_side.neg_x = cdx[31];
        n_a_side.neg_y = cdy[31];
        n_a_side.mx    = cdx[31] ? 32'(-cdx) : cdx;
        n_a_side.my    = cdy[31] ? 32'(-cdy) : cdy;
        n_a_side.sat   = ovx || ovy;
        n_a_side.skip  = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stage B: squares. Stage C: sum of squares (Q32.32, below 2^64).
    // ------------------------------------------------------------------
    t_side       r_b_side;
    logic        r_b_v;
    logic [63:0] r_b_sqx;
    logic [63:0] r_b_sqy;
    t_side       r_c_side;
    logic        r_c_v;
    logic [63:0] r_c_sum;

    // ------------------------------------------------------------------
    // Square root.
    // ------------------------------------------------------------------
    logic        sq_v;
    logic [31:0] sq_d;
    t_side       sq_side;

    pgs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_c_v),
        .i_radicand (r_c_sum),
        .i_side     (r_c_side),
        .o_valid    (sq_v),
        .o_root     (sq_d),
        .o_side     (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage D: skip decision, d^2 and G*m.
    // ------------------------------------------------------------------
    t_side       n_d_side;
    t_side       r_d_side;
    logic        r_d_v;
    logic [63:0] r_d_d2;
    logic [63:0] r_d_gm;
    logic [31:0] r_d_d;

    always_comb begin
        n_d_side      = sq_side;
        n_d_side.skip = (sq_d == 32'd0) || (sq_d < r_min_dist);
    end

    // ------------------------------------------------------------------
    // Divider: acceleration and unit direction.
    // ------------------------------------------------------------------
    logic        dv_v;
    logic [31:0] dv_acc;
    logic        dv_acc_sat;
    logic [16:0] dv_ux;
    logic [16:0] dv_uy;
    t_side       dv_side;

    pgs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_d_v),
        .i_gm      (r_d_gm),
        .i_d2      (r_d_d2),
        .i_d       (r_d_d),
        .i_side    (r_d_side),
        .o_valid   (dv_v),
        .o_acc     (dv_acc),
        .o_acc_sat (dv_acc_sat),
        .o_ux      (dv_ux),
        .o_uy      (dv_uy),
        .o_side    (dv_side)
    );

    // ------------------------------------------------------------------
    // Stage E: acceleration components |a| = |u| * acc >> 16, which stays
    // below 2^32 because |u| never exceeds 1.0.
    // ------------------------------------------------------------------
    t_side       n_e_side;
    t_side       r_e_side;
    logic        r_e_v;
    logic [48:0] prod_ax;
    logic [48:0] prod_ay;
    logic [31:0] r_e_axm;
    logic [31:0] r_e_aym;

    always_comb begin
        prod_ax      = 49'(dv_ux) * 49'(dv_acc);
        prod_ay      = 49'(dv_uy) * 49'(dv_acc);
        n_e_side     = dv_side;
        n_e_side.sat = dv_side.sat || (!dv_side.skip && dv_acc_sat);
    end

    // ------------------------------------------------------------------
    // Stage F: velocity increments |dv| = |a| * dt >> 16.
    // ------------------------------------------------------------------
    t_side       r_f_side;
    logic        r_f_v;
    logic [63:0] prod_dvx;
    logic [63:0] prod_dvy;
    logic [47:0] r_f_dvx;
    logic [47:0] r_f_dvy;

    assign prod_dvx = 64'(r_e_axm) * 64'(r_time_step);
    assign prod_dvy = 64'(r_e_aym) * 64'(r_time_step);

    // ------------------------------------------------------------------
    // Stage G: new velocity with saturation.
    // ------------------------------------------------------------------
    t_side              n_g_side;
    t_side              r_g_side;
    logic               r_g_v;
    logic signed [49:0] sum_vx;
    logic signed [49:0] sum_vy;
    logic signed [31:0] r_g_nvx;
    logic signed [31:0] r_g_nvy;

    always_comb begin
        sum_vx = 50'(r_f_side.vx) + (r_f_side.neg_x ? -$signed({2'b00, r_f_dvx})
                                                     :  $signed({2'b00, r_f_dvx}));
        sum_vy = 50'(r_f_side.vy) + (r_f_side.neg_y ? -$signed({2'b00, r_f_dvy})
                                                     :  $signed({2'b00, r_f_dvy}));
        n_g_side     = r_f_side;
        n_g_side.sat = r_f_side.sat ||
                       (!r_f_side.skip && (ovf50(sum_vx) || ovf50(sum_vy)));
    end

    // ------------------------------------------------------------------
    // Stage H: position increments |dp| = |new v| * dt >> 16.
    // ------------------------------------------------------------------
    t_side              r_h_side;
    logic               r_h_v;
    logic [31:0]        mag_nvx;
    logic [31:0]        mag_nvy;
    logic [63:0]        prod_dpx;
    logic [63:0]        prod_dpy;
    logic [47:0]        r_h_dpx;
    logic [47:0]        r_h_dpy;
    logic signed [31:0] r_h_nvx;
    logic signed [31:0] r_h_nvy;

    always_comb begin
        mag_nvx  = r_g_nvx[31] ? 32'(-r_g_nvx) : r_g_nvx;
        mag_nvy  = r_g_nvy[31] ? 32'(-r_g_nvy) : r_g_nvy;
        prod_dpx = 64'(mag_nvx) * 64'(r_time_step);
        prod_dpy = 64'(mag_nvy) * 64'(r_time_step);
    end

    // ------------------------------------------------------------------
    // Tail: new position with saturation, and the too-close bypass.
    // ------------------------------------------------------------------
    logic signed [49:0] sum_px;
    logic signed [49:0] sum_py;
    t_result            tail;

    always_comb begin
        sum_px = 50'(r_h_side.sx) + (r_h_nvx[31] ? -$signed({2'b00, r_h_dpx})
                                                 :  $signed({2'b00, r_h_dpx}));
        sum_py = 50'(r_h_side.sy) + (r_h_nvy[31] ? -$signed({2'b00, r_h_dpy})
                                                 :  $signed({2'b00, r_h_dpy}));
        if (r_h_side.skip) begin
            tail.new_x     = r_h_side.sx;
            tail.new_y     = r_h_side.sy;
            tail.new_vx    = r_h_side.vx;
            tail.new_vy    = r_h_side.vy;
            tail.saturated = r_h_side.sat;
        end else begin
            tail.new_x     = clamp50(sum_px);
            tail.new_y     = clamp50(sum_py);
            tail.new_vx    = r_h_nvx;
            tail.new_vy    = r_h_nvy;
            tail.saturated = r_h_side.sat || ovf50(sum_px) || ovf50(sum_py);
        end
        tail.skipped = r_h_side.skip;
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= sq_v;
            r_e_v <= dv_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
            r_b_side <= r_a_side;
            r_b_sqx  <= 64'(r_a_side.mx) * 64'(r_a_side.mx);
            r_b_sqy  <= 64'(r_a_side.my) * 64'(r_a_side.my);
            r_c_side <= r_b_side;
            r_c_sum  <= r_b_sqx + r_b_sqy;
            r_d_side <= n_d_side;
            r_d_d2   <= 64'(sq_d) * 64'(sq_d);
            r_d_gm   <= 64'(r_gravity) * 64'(sq_side.mass);
            r_d_d    <= sq_d;
            r_e_side <= n_e_side;
            r_e_axm  <= prod_ax[47:16];
            r_e_aym  <= prod_ay[47:16];
            r_f_side <= r_e_side;
            r_f_dvx  <= prod_dvx[63:16];
            r_f_dvy  <= prod_dvy[63:16];
            r_g_side <= n_g_side;
            r_g_nvx  <= clamp50(sum_vx);
            r_g_nvy  <= clamp50(sum_vy);
            r_h_side <= r_g_side;
            r_h_dpx  <= prod_dpx[63:16];
            r_h_dpy  <= prod_dpy[63:16];
            r_h_nvx  <= r_g_nvx;
            r_h_nvy  <= r_g_nvy;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid slot behind it. A result leaving the
    // pipeline goes to the output register when that is free or being
    // drained, otherwise into the skid slot, which then stops the pipeline.
    // ------------------------------------------------------------------
    logic    r_o_valid;
    t_result r_o_data;
    t_result r_s_data;
    logic    take;
    logic    push;

    assign take = r_o_valid && i_ready;
    assign push = en && r_h_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (take) begin
                r_s_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_o_valid || take) begin
                r_o_valid <= 1'b1;
            end else begin
                r_s_valid <= 1'b1;
            end
        end else if (take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (take) begin
                r_o_data <= r_s_data;
            end
        end else if (push) begin
            if (!r_o_valid || take) begin
                r_o_data <= tail;
            end else begin
                r_s_data <= tail;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_new_x     = r_o_data.new_x;
    assign o_new_y     = r_o_data.new_y;
    assign o_new_vx    = r_o_data.new_vx;
    assign o_new_vy    = r_o_data.new_vy;
    assign o_skipped   = r_o_data.skipped;
    assign o_saturated = r_o_data.saturated;

endmodule

[rtl/core/pgs_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity step port checker
// Watches the top-level ports for output holding and back-pressure behavior.
// ----------------------------------------------------------------------------
module pgs_check
    import pgs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_new_x,
    input logic signed [31:0] o_new_y,
    input logic signed [31:0] o_new_vx,
    input logic signed [31:0] o_new_vy,
    input logic               o_skipped,
    input logic               o_saturated
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_x) && $stable(o_new_y) &&
            $stable(o_new_vx) && $stable(o_new_vy) && $stable(o_skipped) &&
            $stable(o_saturated))
        else $error("stalled result changed");

    // Requests are refused only when a result is waiting at the output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input refused with empty output");

    // Once full, the skid slot stays full until the output drains.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && !i_ready |=> !o_ready)
        else $error("skid slot emptied without a drain");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending after reset");

endmodule

bind pairwise_gravity_euler_step_top pgs_check u_pgs_check (.*);

[tb/tb_pairwise_gravity_euler_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise gravity step testbench
// Streams body/partner requests through the gravity step block under random
// idling on both sides, predicts every result in fixed point and compares
// them in order, over several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_euler_step_top;
    import pgs_pkg::*;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        mass;
    } t_pair;

    // Scoreboard: predicts the updated body of each accepted request and
    // holds the predictions until the matching results come out.
    class gravity_scoreboard;
        longint unsigned gravity;
        longint unsigned dt;
        longint unsigned min_dist;
        t_result         pending[$];
        int              errors;
        int              checked;
        int              skips;
        int              sats;

        function new();
            gravity  = GRAVITY_RESET;
            dt       = TIME_STEP_RESET;
            min_dist = MIN_DIST_RESET;
            errors   = 0;
            checked  = 0;
            skips    = 0;
            sats     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_GRAVITY:   gravity  = data;
                CFG_TIME_STEP: dt       = data;
                CFG_MIN_DIST:  min_dist = data;
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v, ref bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint unsigned mag(longint a);
            return (a < 0) ? longint'(-a) : longint'(a);
        endfunction

        function longint unsigned isqrt(longint unsigned s);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (s >= res + bitv) begin
                    s   = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // (a * b) >> 16 on magnitudes, sign of a restored.
        function longint scale_q16(longint a, longint unsigned b);
            longint unsigned p;
            p = (mag(a) * b) >> 16;
            return (a < 0) ? -longint'(p) : longint'(p);
        endfunction

        function longint direction(longint delta, longint unsigned d);
            longint unsigned q;
            q = (mag(delta) << 16) / d;
            return (delta < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_request(t_pair it);
            longint          sx, sy, vx, vy, dx, dy, nx, ny, nvx, nvy, ax, ay;
            longint unsigned mx, my, d, d2, gm, q, r, acc;
            bit              sat, skip;
            t_result         res;
            sat = 0;
            sx  = it.sx;
            sy  = it.sy;
            vx  = it.vx;
            vy  = it.vy;
            dx  = clamp_word(longint'(it.px) - sx, sat);
            dy  = clamp_word(longint'(it.py) - sy, sat);
            mx  = mag(dx);
            my  = mag(dy);
            d   = isqrt(mx * mx + my * my);
            skip = (d == 0) || (d < min_dist);
            nx  = sx;
            ny  = sy;
            nvx = vx;
            nvy = vy;
            if (!skip) begin
                d2 = d * d;
                gm = gravity * longint'(it.mass);
                q  = gm / d2;
                if ((q >> 16) != 0) begin
                    acc = 64'hFFFF_FFFF;
                    sat = 1;
                end else begin
                    r = gm % d2;
                    for (int i = 0; i < 16; i++) begin
                        q = q << 1;
                        r = r << 1;
                        if (r >= d2) begin
                            r = r - d2;
                            q = q | 1;
                        end
                    end
                    acc = q;
                end
                ax  = scale_q16(direction(dx, d), acc);
                ay  = scale_q16(direction(dy, d), acc);
                nvx = clamp_word(vx + scale_q16(ax, dt), sat);
                nvy = clamp_word(vy + scale_q16(ay, dt), sat);
                nx  = clamp_word(sx + scale_q16(nvx, dt), sat);
                ny  = clamp_word(sy + scale_q16(nvy, dt), sat);
            end
            res.new_x     = nx[31:0];
            res.new_y     = ny[31:0];
            res.new_vx    = nvx[31:0];
            res.new_vy    = nvy[31:0];
            res.skipped   = skip;
            res.saturated = sat;
            pending.insert(pending.size(), res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.skipped) skips++;
            if (want.saturated) sats++;
            if (got.new_x !== want.new_x) begin
                $display("%0t: new_x expected %h actual %h", $time, want.new_x, got.new_x);
                errors++;
            end
            if (got.new_y !== want.new_y) begin
                $display("%0t: new_y expected %h actual %h", $time, want.new_y, got.new_y);
                errors++;
            end
            if (got.new_vx !== want.new_vx) begin
                $display("%0t: new_vx expected %h actual %h", $time, want.new_vx,
                         got.new_vx);
                errors++;
            end
            if (got.new_vy !== want.new_vy) begin
                $display("%0t: new_vy expected %h actual %h", $time, want.new_vy,
                         got.new_vy);
                errors++;
            end
            if (got.skipped !== want.skipped) begin
                $display("%0t: skipped expected %b actual %b", $time, want.skipped,
                         got.skipped);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_self_x, i_self_y, i_self_vx, i_self_vy;
    logic signed [31:0] i_partner_x, i_partner_y;
    logic [31:0]        i_partner_mass;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_new_x, o_new_y, o_new_vx, o_new_vy;
    logic               o_skipped, o_saturated;

    gravity_scoreboard sb = new();

    // Receiver controls: a one-off long hold-off and a calm mode with no gaps.
    int rx_hold = 0;
    int rx_gap  = 0;
    bit calm    = 0;
    int sent    = 0;

    pairwise_gravity_euler_step_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_self_x       (i_self_x),
        .i_self_y       (i_self_y),
        .i_self_vx      (i_self_vx),
        .i_self_vy      (i_self_vy),
        .i_partner_x    (i_partner_x),
        .i_partner_y    (i_partner_y),
        .i_partner_mass (i_partner_mass),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_new_x        (o_new_x),
        .o_new_y        (o_new_y),
        .o_new_vx       (o_new_vx),
        .o_new_vy       (o_new_vy),
        .o_skipped      (o_skipped),
        .o_saturated    (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Every accepted result is compared against the oldest prediction. The
    // outputs are sampled at the edge, before any of this edge's updates land.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.new_x     = o_new_x;
            got.new_y     = o_new_y;
            got.new_vx    = o_new_vx;
            got.new_vy    = o_new_vy;
            got.skipped   = o_skipped;
            got.saturated = o_saturated;
            sb.check_result(got);
        end
    end

    // Result side: a random number of idle cycles before each result, and the
    // long hold-off is counted down here when the stimulus asks for it. The
    // next value of ready is worked out first so it is assigned only once.
    always @(posedge i_clk) begin
        logic next_ready;
        if (i_rst_n && o_valid && i_ready) begin
            rx_gap = calm ? 0 : $urandom_range(0, 11);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            next_ready = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        i_ready <= next_ready;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Sends one request after a random gap. Valid is left high when the next
    // request follows without a gap, so it never drops and rises in one step.
    task automatic send_request(t_pair it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_self_x       <= it.sx;
        i_self_y       <= it.sy;
        i_self_vx      <= it.vx;
        i_self_vy      <= it.vy;
        i_partner_x    <= it.px;
        i_partner_y    <= it.py;
        i_partner_mass <= it.mass;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(it);
        sent++;
    endtask

    // Waits until every prediction has been matched, then lets the pipeline
    // run dry for longer than its latency. The request side sits idle here.
    task automatic wait_idle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_pair make_pair(logic signed [31:0] sx, logic signed [31:0] sy,
                                        logic signed [31:0] vx, logic signed [31:0] vy,
                                        logic signed [31:0] px, logic signed [31:0] py,
                                        logic [31:0] mass);
        t_pair it;
        it.sx   = sx;
        it.sy   = sy;
        it.vx   = vx;
        it.vy   = vy;
        it.px   = px;
        it.py   = py;
        it.mass = mass;
        return it;
    endfunction

    // Mostly plausible bodies up to 128 units apart on each axis so the force path is
    // exercised; the rest are close pairs and full-range noise.
    function automatic t_pair random_pair();
        t_pair it;
        int    kind;
        kind    = $urandom_range(0, 9);
        it.sx   = $urandom;
        it.sy   = $urandom;
        it.vx   = $urandom;
        it.vy   = $urandom;
        it.px   = $urandom;
        it.py   = $urandom;
        it.mass = $urandom;
        if (kind < 6) begin
            it.sx   = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            it.sy   = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            it.vx   = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            it.vy   = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            it.px   = it.sx + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            it.py   = it.sy + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            it.mass = $urandom_range(0, 32'h0100_0000);
        end else if (kind < 8) begin
            it.px = it.sx + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            it.py = it.sy + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        end
        return it;
    endfunction

    task automatic run_directed();
        send_request(make_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000));   // zero distance
        send_request(make_pair(0, 0, 5, 7, 32'h8000, 0, 32'h0001_0000)); // too close
        send_request(make_pair(32'sh8000_0000, 32'sh8000_0000, 0, 0,
                               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1)); // huge separation
        send_request(make_pair(32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, 0, 1));
        send_request(make_pair(0, 0, 0, 0, 32'h0001_0000, 0, '1));   // huge acceleration
        send_request(make_pair(0, 0, 0, 0, 0, 32'sh0001_0000, '1));
        send_request(make_pair(0, 0, 0, 0, -32'sh0001_0000, -32'sh0001_0000, '1));
        send_request(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh7FFF_FFFF, 0, 0, '1));
        send_request(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 0, 0, '1));
        send_request(make_pair(0, 0, 32'sh0001_0000, -32'sh0001_0000,
                               32'sh0010_0000, 32'sh0010_0000, 0)); // massless partner
        send_request(make_pair(32'sh0010_0000, -32'sh0030_0000, 0, 0,
                               -32'sh0020_0000, 32'sh0040_0000, 32'h0010_0000));
        send_request(make_pair(0, 0, 0, 0, 32'sh0001_0000, 0, 32'h0001_0000));
        send_request(make_pair(0, 0, 0, 0, 32'sh0000_FFFF, 0, 32'h0001_0000));
        send_request(make_pair(-1, -1, -1, -1, 1, 1, 1));
        send_request(make_pair(0, 0, 32'sh7FFF_0000, 0, 32'sh0100_0000, 0, '1));
    endtask

    initial begin
        logic [31:0] regs [3];
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_self_x       <= '0;
        i_self_y       <= '0;
        i_self_vx      <= '0;
        i_self_vy      <= '0;
        i_partner_x    <= '0;
        i_partner_y    <= '0;
        i_partner_mass <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first, then each phase loads a new register setting.
        run_directed();
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            case (phase)
                0: regs = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
                1: regs = '{32'h0, 32'h0, 32'hFFFF_FFFF};
                2: regs = '{32'h0001_0000, 32'h0000_1000, 32'h0};
                default: regs = '{$urandom_range(0, 32'h0010_0000),
                                  $urandom_range(0, 32'h0001_0000),
                                  $urandom_range(0, 32'h0008_0000)};
            endcase
            write_reg(CFG_GRAVITY, regs[0]);
            write_reg(CFG_TIME_STEP, regs[1]);
            write_reg(CFG_MIN_DIST, regs[2]);
            write_reg(2'd3, $urandom);   // unmapped index must be ignored
            if (phase < 3) begin
                run_directed();
            end
            calm = (phase == 4);
            if (phase == 5) begin
                // Stall the result side long enough for the pipeline to back up.
                rx_hold = 400;
            end
            repeat (225) send_request(random_pair());
            calm = 0;
        end
        wait_idle();

        if (sb.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Covered %0d requests, %0d results checked: %0d skipped, %0d saturated.",
                 sent, sb.checked, sb.skips, sb.sats);
        $display("Register settings: reset values, both extremes and random mid values.");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
